// ===== rtl/flow_dedup_hash_port_select_macros.svh =====
// Assertion macros shared by the flow dedup and port select RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef FLOW_DEDUP_HASH_PORT_SELECT_MACROS_SVH
`define FLOW_DEDUP_HASH_PORT_SELECT_MACROS_SVH

`define FDH_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define FDH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define FDH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fdh_pkg.sv =====
// Shared constants, types and helpers for the flow dedup and port select block.
// Used by every module of the block; depends on nothing.
package fdh_pkg;

  localparam int NODE_COUNT    = 1024;
  localparam int FLOW_CAPACITY = 4096;
  localparam int NODE_W        = 10;
  localparam int PAIR_W        = $clog2(NODE_COUNT * NODE_COUNT);
  localparam int MAP_WORDS     = (NODE_COUNT * NODE_COUNT + 63) / 64;
  localparam int MAP_AW        = $clog2(MAP_WORDS);
  localparam int REC_AW        = $clog2(FLOW_CAPACITY);
  localparam int CNT_W         = 13;
  localparam int PC_W          = 9;
  localparam int CPL_W         = 11;
  localparam int PORT_W        = 9;
  localparam int CFG_W         = 11;
  localparam int Q_DEPTH       = 2;
  localparam int Q_AW          = 1;

  localparam logic [31:0] HASH_C1 = 32'd2654435761;
  localparam logic [31:0] HASH_C2 = 32'd2246822519;
  localparam logic [31:0] HASH_C3 = 32'h045d9f3b;
  localparam int          HASH_SH = 16;

  localparam logic [PORT_W-1:0] PORT_LOCAL = '1;
  localparam logic KIND_FLOW = 1'b0;
  localparam logic KIND_END  = 1'b1;
  localparam logic CFG_PORT_COUNT     = 1'b0;
  localparam logic CFG_CARDS_PER_LEAF = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [PORT_W-1:0] port;
  } fdh_item_t;

  typedef struct packed {
    logic [PC_W-1:0]  port_count;
    logic [CPL_W-1:0] cards_per_leaf;
  } fdh_cfg_t;

  function automatic logic [PAIR_W-1:0] pair_index(input logic [NODE_W-1:0] src,
                                                   input logic [NODE_W-1:0] dst);
    return PAIR_W'(32'(src) * NODE_COUNT + 32'(dst));
  endfunction

endpackage

// ===== rtl/fdh_fifo.sv =====
// Short request queue between the front and back parts.
// Depends on fdh_pkg for the item type and depth.
module fdh_fifo
  import fdh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  fdh_item_t item_in,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output fdh_item_t item_out
);

  fdh_item_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign full     = cnt_r == (Q_AW+1)'(Q_DEPTH);
  assign empty    = cnt_r == '0;
  assign item_out = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt = wp_r + 1'b1;
    end
    if (pop && !empty) begin
      rp_nxt = rp_r + 1'b1;
    end
    if ((push && !full) && !(pop && !empty)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!(push && !full) && (pop && !empty)) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= item_in;
    end
  end

endmodule

// ===== rtl/fdh_front.sv =====
// Front part: accepts requests, computes the pair hash, the leaf test and the port.
// Depends on fdh_pkg; feeds fdh_fifo.
module fdh_front
  import fdh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic [NODE_W-1:0] in_source_node,
  input  logic [NODE_W-1:0] in_dest_node,
  input  fdh_cfg_t          cfg,
  input  logic              back_ready,
  input  logic              q_full,
  output logic              q_push,
  output fdh_item_t         q_item
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HASH = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic [4:0]        step_r, step_nxt;
  fdh_item_t         item_r, item_nxt;
  logic [31:0]       h_r, h_nxt;
  logic [7:0]        rem_r, rem_nxt;
  logic [NODE_W-1:0] qs_r, qs_nxt, qd_r, qd_nxt, rs_r, rs_nxt, rd_r, rd_nxt;
  logic [PC_W-1:0]   pc_eff;
  logic [CPL_W-1:0]  cpl_eff;
  logic [PC_W-1:0]   t_pc;
  logic [CPL_W-1:0]  ts, td;
  logic              accept;

  assign in_stall = (st_r != F_IDLE) || !back_ready;
  assign accept   = in_valid && !in_stall;
  assign q_push   = (st_r == F_PUSH) && !q_full;
  assign q_item   = item_r;

  always_comb begin
    pc_eff = cfg.port_count;
    if (cfg.port_count == '0) begin
      pc_eff = PC_W'(1);
    end else if (cfg.port_count > PC_W'(256)) begin
      pc_eff = PC_W'(256);
    end
    cpl_eff = (cfg.cards_per_leaf == '0) ? CPL_W'(1) : cfg.cards_per_leaf;
  end

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    item_nxt = item_r;
    h_nxt    = h_r;
    rem_nxt  = rem_r;
    qs_nxt   = qs_r;
    qd_nxt   = qd_r;
    rs_nxt   = rs_r;
    rd_nxt   = rd_r;
    t_pc     = {rem_r, h_r[31]};
    ts       = {rs_r, qs_r[NODE_W-1]};
    td       = {rd_r, qd_r[NODE_W-1]};
    unique case (st_r)
      F_IDLE: begin
        if (accept) begin
          item_nxt.kind = in_req_type;
          item_nxt.src  = in_source_node;
          item_nxt.dst  = in_dest_node;
          item_nxt.port = '0;
          qs_nxt        = in_source_node;
          qd_nxt        = in_dest_node;
          rs_nxt        = '0;
          rd_nxt        = '0;
          rem_nxt       = '0;
          step_nxt      = '0;
          if (in_req_type == KIND_END) begin
            item_nxt.src = '0;
            item_nxt.dst = '0;
            st_nxt       = F_PUSH;
          end else if ((32'(in_source_node) < NODE_COUNT) &&
                       (32'(in_dest_node) < NODE_COUNT)) begin
            st_nxt = F_HASH;
          end
        end
      end
      F_HASH: begin
        step_nxt = step_r + 1'b1;
        case (step_r[1:0])
          2'd0: h_nxt = 32'(item_r.src) * HASH_C1;
          2'd1: h_nxt = h_r ^ (32'(item_r.dst) * HASH_C2);
          2'd2: h_nxt = ((h_r >> HASH_SH) ^ h_r) * HASH_C3;
          default: begin
            h_nxt    = (h_r >> HASH_SH) ^ h_r;
            step_nxt = '0;
            st_nxt   = F_DIV;
          end
        endcase
      end
      F_DIV: begin
        step_nxt = step_r + 1'b1;
        h_nxt    = {h_r[30:0], 1'b0};
        rem_nxt  = (t_pc >= pc_eff) ? 8'(t_pc - pc_eff) : t_pc[7:0];
        if (32'(step_r) < NODE_W) begin
          if (ts >= cpl_eff) begin
            rs_nxt = NODE_W'(ts - cpl_eff);
            qs_nxt = {qs_r[NODE_W-2:0], 1'b1};
          end else begin
            rs_nxt = ts[NODE_W-1:0];
            qs_nxt = {qs_r[NODE_W-2:0], 1'b0};
          end
          if (td >= cpl_eff) begin
            rd_nxt = NODE_W'(td - cpl_eff);
            qd_nxt = {qd_r[NODE_W-2:0], 1'b1};
          end else begin
            rd_nxt = td[NODE_W-1:0];
            qd_nxt = {qd_r[NODE_W-2:0], 1'b0};
          end
        end
        if (step_r == 5'd31) begin
          item_nxt.port = (qs_r == qd_r) ? PORT_LOCAL : {1'b0, rem_nxt};
          st_nxt        = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      step_r <= '0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    h_r    <= h_nxt;
    rem_r  <= rem_nxt;
    qs_r   <= qs_nxt;
    qd_r   <= qd_nxt;
    rs_r   <= rs_nxt;
    rd_r   <= rd_nxt;
  end

endmodule

// ===== rtl/fdh_back.sv =====
// Back part: seen-pair bitmap, recorded pair list, flow count and result register.
// Depends on fdh_pkg and the assertion macros; takes items from fdh_fifo.
`include "flow_dedup_hash_port_select_macros.svh"
module fdh_back
  import fdh_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  fdh_item_t                q_item,
  output logic                     q_pop,
  output logic                     init_done,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_result_kind,
  output logic [NODE_W-1:0]        out_source_node_out,
  output logic [NODE_W-1:0]        out_dest_node_out,
  output logic signed [PORT_W-1:0] out_egress_port,
  output logic [CNT_W-1:0]         out_flow_total,
  output logic                     out_overflow
);

  localparam logic [1:0] B_INIT  = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_CHECK = 2'd2;
  localparam logic [1:0] B_SWEEP = 2'd3;

  logic [63:0]       seen_mem [MAP_WORDS];
  logic [PAIR_W-1:0] rec_mem  [FLOW_CAPACITY];

  logic [1:0]        st_r, st_nxt;
  logic [MAP_AW-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, sw_r, sw_nxt;
  logic              pend_r, pend_nxt;
  fdh_item_t         cur_r, cur_nxt;
  logic [63:0]       seen_q_r;
  logic [PAIR_W-1:0] rec_q_r;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [NODE_W-1:0] out_src_r, out_src_nxt, out_dst_r, out_dst_nxt;
  logic [PORT_W-1:0] out_port_r, out_port_nxt;
  logic [CNT_W-1:0]  out_total_r, out_total_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              out_free, full;
  logic [PAIR_W-1:0] head_pair, cur_pair;
  logic [MAP_AW-1:0] seen_ra, seen_wa;
  logic [63:0]       seen_wd;
  logic              seen_we, rec_we;
  logic [REC_AW-1:0] rec_ra;

  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (st_r == B_IDLE) && !q_empty && out_free;
  assign init_done = st_r != B_INIT;
  assign head_pair = pair_index(q_item.src, q_item.dst);
  assign cur_pair  = pair_index(cur_r.src, cur_r.dst);
  assign seen_ra   = head_pair[PAIR_W-1:6];
  assign rec_ra    = sw_r[REC_AW-1:0];
  assign full      = cnt_r >= CNT_W'(FLOW_CAPACITY);

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_source_node_out = out_src_r;
  assign out_dest_node_out   = out_dst_r;
  assign out_egress_port     = out_port_r;
  assign out_flow_total      = out_total_r;
  assign out_overflow        = out_ovf_r;

  always_comb begin
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    sw_nxt        = sw_r;
    pend_nxt      = pend_r;
    cur_nxt       = cur_r;
    seen_we       = 1'b0;
    seen_wa       = cur_pair[PAIR_W-1:6];
    seen_wd       = '0;
    rec_we        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_src_nxt   = out_src_r;
    out_dst_nxt   = out_dst_r;
    out_port_nxt  = out_port_r;
    out_total_nxt = out_total_r;
    out_ovf_nxt   = out_ovf_r;
    unique case (st_r)
      B_INIT: begin
        seen_we = 1'b1;
        seen_wa = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == MAP_AW'(MAP_WORDS - 1)) begin
          st_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_pop) begin
          cur_nxt = q_item;
          if (q_item.kind == KIND_END) begin
            sw_nxt   = '0;
            pend_nxt = 1'b0;
            st_nxt   = B_SWEEP;
          end else begin
            st_nxt = B_CHECK;
          end
        end
      end
      B_CHECK: begin
        st_nxt = B_IDLE;
        if (!seen_q_r[cur_pair[5:0]]) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FLOW;
          out_src_nxt   = cur_r.src;
          out_dst_nxt   = cur_r.dst;
          out_port_nxt  = cur_r.port;
          out_total_nxt = '0;
          out_ovf_nxt   = full;
          if (!full) begin
            seen_we = 1'b1;
            seen_wd = seen_q_r | (64'd1 << cur_pair[5:0]);
            rec_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      B_SWEEP: begin
        if (sw_r != cnt_r) begin
          sw_nxt   = sw_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          seen_we = 1'b1;
          seen_wa = rec_q_r[PAIR_W-1:6];
        end
        if ((sw_r == cnt_r) && !pend_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_END;
          out_src_nxt   = '0;
          out_dst_nxt   = '0;
          out_port_nxt  = '0;
          out_total_nxt = cnt_r;
          out_ovf_nxt   = 1'b0;
          cnt_nxt       = '0;
          st_nxt        = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_INIT;
      clr_r       <= '0;
      cnt_r       <= '0;
      sw_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      sw_r        <= sw_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    out_kind_r  <= out_kind_nxt;
    out_src_r   <= out_src_nxt;
    out_dst_r   <= out_dst_nxt;
    out_port_r  <= out_port_nxt;
    out_total_r <= out_total_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[seen_wa] <= seen_wd;
    end
    seen_q_r <= seen_mem[seen_ra];
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[cnt_r[REC_AW-1:0]] <= cur_pair;
    end
    rec_q_r <= rec_mem[rec_ra];
  end

  `FDH_ASSERT(a_cnt_cap, cnt_r <= CNT_W'(FLOW_CAPACITY), "flow count above capacity")
  `FDH_ASSERT_IMP(a_pop_free, q_pop, out_free, "request taken while result register busy")
  `FDH_ASSERT_IMP(a_check_empty, st_r == B_CHECK, !out_valid_r, "result register busy at check")
  `FDH_ASSERT_NEXT(a_summary, (st_r == B_SWEEP) && (sw_r == cnt_r) && !pend_r,
                   out_valid_r && (out_kind_r == KIND_END) && (cnt_r == '0),
                   "job summary not issued or count not cleared")

endmodule

// ===== rtl/flow_dedup_hash_port_select.sv =====
// Flow requests are taken on the in_ channel; new flows and job summaries leave on the out_
// channel. In the front part a flow request goes through four hash steps, then a
// bit-serial modulo of the 32-bit hash by port_count (one bit a cycle, with the leaf
// division alongside), then a push into a two-entry queue. The back part then does a
// read-modify-write of the seen-pair bitmap word for each flow. An end of job clears the
// bitmap word of every recorded flow and then issues the job summary. After reset all
// 16384 bitmap words are swept clear, during which in_stall is held high.
module flow_dedup_hash_port_select
  import fdh_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_req_type,
  input  logic [NODE_W-1:0]        in_source_node,
  input  logic [NODE_W-1:0]        in_dest_node,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_result_kind,
  output logic [NODE_W-1:0]        out_source_node_out,
  output logic [NODE_W-1:0]        out_dest_node_out,
  output logic signed [PORT_W-1:0] out_egress_port,
  output logic [CNT_W-1:0]         out_flow_total,
  output logic                     out_overflow
);

  fdh_cfg_t  cfg_r, cfg_nxt;
  logic      q_push, q_pop, q_full, q_empty, back_ready;
  fdh_item_t push_item, head_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PORT_COUNT:     cfg_nxt.port_count     = cfg_wdata[PC_W-1:0];
        CFG_CARDS_PER_LEAF: cfg_nxt.cards_per_leaf = cfg_wdata[CPL_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.port_count     <= PC_W'(1);
      cfg_r.cards_per_leaf <= CPL_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fdh_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_source_node (in_source_node),
    .in_dest_node   (in_dest_node),
    .cfg            (cfg_r),
    .back_ready     (back_ready),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  fdh_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .item_in  (push_item),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .item_out (head_item)
  );

  fdh_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_item              (head_item),
    .q_pop               (q_pop),
    .init_done           (back_ready),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_source_node_out (out_source_node_out),
    .out_dest_node_out   (out_dest_node_out),
    .out_egress_port     (out_egress_port),
    .out_flow_total      (out_flow_total),
    .out_overflow        (out_overflow)
  );

endmodule
